>>> design/lem_pkg.sv
// Shared types and constants for the liveness escalation monitor.
// No dependencies; imported by liveness_escalation_monitor.
`timescale 1ns / 1ps

package lem_pkg;

    // Counter width default and fixed field widths
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int TALLY_W         = 8;
    localparam int HB_W            = 16;
    localparam int CODE_W          = 3;
    localparam int IDX_W           = 4;
    localparam int IN_TDATA_W      = 24;
    localparam int OUT_TDATA_W     = 24;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PIN_TIMEOUT     = 4'd0,
        REG_BUS_TIMEOUT     = 4'd1,
        REG_RESET_HOLD      = 4'd2,
        REG_RESET_MAX       = 4'd3,
        REG_POWER_OFF_TICKS = 4'd4,
        REG_CYCLE_MAX       = 4'd5,
        REG_SURV_EXIT_TICKS = 4'd6,
        REG_RECOVER_MAX     = 4'd7
    } cfg_reg_t;

    // Configuration reset values
    localparam logic [CFG_W-1:0]   PIN_TIMEOUT_RST     = 16'd5;
    localparam logic [CFG_W-1:0]   BUS_TIMEOUT_RST     = 16'd10;
    localparam logic [CFG_W-1:0]   RESET_HOLD_RST      = 16'd2;
    localparam logic [TALLY_W-1:0] RESET_MAX_RST       = 8'd3;
    localparam logic [CFG_W-1:0]   POWER_OFF_TICKS_RST = 16'd5;
    localparam logic [TALLY_W-1:0] CYCLE_MAX_RST       = 8'd3;
    localparam logic [CFG_W-1:0]   SURV_EXIT_TICKS_RST = 16'd60;
    localparam logic [TALLY_W-1:0] RECOVER_MAX_RST     = 8'd3;

    // Escalation state, one-hot
    typedef enum logic [5:0] {
        ST_OK    = 6'b000001,
        ST_BUS   = 6'b000010,
        ST_PIN   = 6'b000100,
        ST_RESET = 6'b001000,
        ST_CYCLE = 6'b010000,
        ST_SURV  = 6'b100000
    } esc_state_t;

    // Reported state codes
    localparam logic [CODE_W-1:0] CODE_OK    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_BUS   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_PIN   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RESET = 3'd3;
    localparam logic [CODE_W-1:0] CODE_CYCLE = 3'd4;
    localparam logic [CODE_W-1:0] CODE_SURV  = 3'd5;

    // Saturating tally increment
    function automatic logic [TALLY_W-1:0] tally_inc(input logic [TALLY_W-1:0] v);
        tally_inc = (v == TALLY_MAX) ? v : v + TALLY_W'(1);
    endfunction

endpackage

>>> design/liveness_escalation_monitor.sv
// Liveness escalation monitor top level: poll-tick stream in, one result beat out per tick.
// Depends on lem_pkg.
`timescale 1ns / 1ps

// Each accepted poll beat is processed in the cycle it is taken: the stall counters,
// tallies and escalation state update at that edge and the result lands in the output
// register, so the result is offered in the cycle after its input. One beat is accepted
// every clock; s_tready stays high while the output register is empty or being drained
// in the same cycle, so throughput is one beat per cycle with one result per beat.
// There is no clearing pass after reset. Configuration writes take effect at the edge
// where cfg_we is high; indexes above seven are ignored.
module liveness_escalation_monitor
    import lem_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Poll beat: pin_one_level, pin_two_level, bus_read_ok, heartbeat_value[15:0],
    // critical_fault, zero fill
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // Result beat: heartbeat_out, reset_released, power_enable, live_state[2:0],
    // missed_beat_fault, link_error_fault, bus_recover_request, safe_mode_command,
    // powercycle_tally[7:0], zero fill
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // Configuration write port
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // Configuration registers
    logic [CFG_W-1:0]   pin_timeout_reg, bus_timeout_reg, reset_hold_reg;
    logic [CFG_W-1:0]   power_off_ticks_reg, surv_exit_ticks_reg;
    logic [TALLY_W-1:0] reset_max_reg, cycle_max_reg, recover_max_reg;

    // Monitor state
    esc_state_t         state_reg, state_next;
    logic               beat_reg, beat_next;
    logic               last_p1_reg, last_p1_next;
    logic               last_p2_reg, last_p2_next;
    logic [HB_W-1:0]    last_cnt_reg, last_cnt_next;
    logic               first_reg, first_next;
    logic [CW-1:0]      pin_cnt_reg, pin_cnt_next;
    logic [CW-1:0]      bus_cnt_reg, bus_cnt_next;
    logic [CW-1:0]      off_cnt_reg, off_cnt_next;
    logic [CW-1:0]      stable_cnt_reg, stable_cnt_next;
    logic [TALLY_W-1:0] reset_tally_reg, reset_tally_next;
    logic [TALLY_W-1:0] recover_tally_reg, recover_tally_next;
    logic [TALLY_W-1:0] cycle_tally_reg, cycle_tally_next;
    logic               reset_line_reg, reset_line_next;
    logic               power_line_reg, power_line_next;

    // Output register
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // Unpacked input fields
    logic            in_p1, in_p2, in_rd_ok, in_crit;
    logic [HB_W-1:0] in_hb;

    // Per-beat pulses and flags
    logic            missed, link, recover, safe, toggled;
    logic [CODE_W-1:0] code;

    logic accept;

    assign in_p1    = s_tdata[0];
    assign in_p2    = s_tdata[1];
    assign in_rd_ok = s_tdata[2];
    assign in_hb    = s_tdata[3 +: HB_W];
    assign in_crit  = s_tdata[3 + HB_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_timeout_reg     <= PIN_TIMEOUT_RST;
            bus_timeout_reg     <= BUS_TIMEOUT_RST;
            reset_hold_reg      <= RESET_HOLD_RST;
            reset_max_reg       <= RESET_MAX_RST;
            power_off_ticks_reg <= POWER_OFF_TICKS_RST;
            cycle_max_reg       <= CYCLE_MAX_RST;
            surv_exit_ticks_reg <= SURV_EXIT_TICKS_RST;
            recover_max_reg     <= RECOVER_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIN_TIMEOUT:     pin_timeout_reg     <= cfg_data;
                REG_BUS_TIMEOUT:     bus_timeout_reg     <= cfg_data;
                REG_RESET_HOLD:      reset_hold_reg      <= cfg_data;
                REG_RESET_MAX:       reset_max_reg       <= cfg_data[TALLY_W-1:0];
                REG_POWER_OFF_TICKS: power_off_ticks_reg <= cfg_data;
                REG_CYCLE_MAX:       cycle_max_reg       <= cfg_data[TALLY_W-1:0];
                REG_SURV_EXIT_TICKS: surv_exit_ticks_reg <= cfg_data;
                REG_RECOVER_MAX:     recover_max_reg     <= cfg_data[TALLY_W-1:0];
                default:             ;
            endcase
        end
    end

    // Per-tick update of counters, tallies and escalation state
    always_comb
    begin
        state_next         = state_reg;
        beat_next          = !beat_reg;
        last_p1_next       = last_p1_reg;
        last_p2_next       = last_p2_reg;
        last_cnt_next      = last_cnt_reg;
        first_next         = 1'b0;
        pin_cnt_next       = pin_cnt_reg;
        bus_cnt_next       = bus_cnt_reg;
        off_cnt_next       = off_cnt_reg;
        stable_cnt_next    = stable_cnt_reg;
        reset_tally_next   = reset_tally_reg;
        recover_tally_next = recover_tally_reg;
        cycle_tally_next   = cycle_tally_reg;
        reset_line_next    = reset_line_reg;
        power_line_next    = power_line_reg;
        missed             = 1'b0;
        link               = 1'b0;
        recover            = 1'b0;
        safe               = 1'b0;

        // Pin activity check
        toggled = (in_p1 != last_p1_reg) || (in_p2 != last_p2_reg);
        if (toggled || first_reg)
        begin
            pin_cnt_next = '0;
            last_p1_next = in_p1;
            last_p2_next = in_p2;
        end
        else if (pin_cnt_reg != CNT_MAX)
        begin
            pin_cnt_next = pin_cnt_reg + CW'(1);
            if (CMP_W'(pin_cnt_next) == CMP_W'(pin_timeout_reg))
                missed = 1'b1;
        end

        // Bus counter activity check
        if (in_rd_ok && ((in_hb != last_cnt_reg) || first_reg))
        begin
            bus_cnt_next       = '0;
            recover_tally_next = '0;
            last_cnt_next      = in_hb;
        end
        else
        begin
            if (bus_cnt_reg != CNT_MAX)
                bus_cnt_next = bus_cnt_reg + CW'(1);
            if (!in_rd_ok)
            begin
                link = 1'b1;
                if (recover_tally_reg < recover_max_reg)
                begin
                    recover_tally_next = recover_tally_reg + TALLY_W'(1);
                    recover            = 1'b1;
                end
            end
        end

        // Escalation
        unique case (state_reg)
            ST_OK:
            begin
                if (CMP_W'(pin_cnt_next) >= CMP_W'(pin_timeout_reg))
                begin
                    state_next   = ST_PIN;
                    pin_cnt_next = '0;
                end
                else if (CMP_W'(bus_cnt_next) >= CMP_W'(bus_timeout_reg))
                begin
                    state_next   = ST_BUS;
                    bus_cnt_next = '0;
                end
                else if (toggled)
                    reset_tally_next = '0;
            end
            ST_BUS:
            begin
                if (bus_cnt_next == '0)
                    state_next = ST_OK;
                else if (CMP_W'(pin_cnt_next) >= CMP_W'(pin_timeout_reg))
                begin
                    state_next   = ST_PIN;
                    pin_cnt_next = '0;
                end
            end
            ST_PIN:
            begin
                reset_line_next = 1'b0;
                state_next      = ST_RESET;
                pin_cnt_next    = '0;
                bus_cnt_next    = '0;
            end
            ST_RESET:
            begin
                // The pin stall count doubles as the hold counter here
                if (CMP_W'(pin_cnt_next) >= CMP_W'(reset_hold_reg))
                begin
                    reset_line_next  = 1'b1;
                    pin_cnt_next     = '0;
                    bus_cnt_next     = '0;
                    first_next       = 1'b1;
                    reset_tally_next = tally_inc(reset_tally_reg);
                    state_next       = (reset_tally_next >= reset_max_reg) ? ST_CYCLE : ST_OK;
                end
                else if (toggled)
                begin
                    reset_line_next = 1'b1;
                    pin_cnt_next    = '0;
                    bus_cnt_next    = '0;
                    state_next      = ST_OK;
                end
                else if (pin_cnt_next != CNT_MAX)
                    pin_cnt_next = pin_cnt_next + CW'(1);
            end
            ST_CYCLE:
            begin
                if (off_cnt_reg == '0)
                begin
                    reset_line_next  = 1'b0;
                    power_line_next  = 1'b0;
                    cycle_tally_next = tally_inc(cycle_tally_reg);
                end
                if (off_cnt_reg != CNT_MAX)
                    off_cnt_next = off_cnt_reg + CW'(1);
                if (CMP_W'(off_cnt_next) >= CMP_W'(power_off_ticks_reg))
                begin
                    // Power back up
                    off_cnt_next     = '0;
                    power_line_next  = 1'b1;
                    reset_line_next  = 1'b1;
                    first_next       = 1'b1;
                    pin_cnt_next     = '0;
                    bus_cnt_next     = '0;
                    reset_tally_next = '0;
                    if (cycle_tally_next >= cycle_max_reg)
                        state_next = ST_SURV;
                    else
                    begin
                        safe       = 1'b1;
                        state_next = ST_OK;
                    end
                end
            end
            ST_SURV:
            begin
                reset_line_next = 1'b0;
                power_line_next = 1'b0;
                if ((surv_exit_ticks_reg != '0) && !in_crit)
                begin
                    if (stable_cnt_reg != CNT_MAX)
                        stable_cnt_next = stable_cnt_reg + CW'(1);
                    if (CMP_W'(stable_cnt_next) >= CMP_W'(surv_exit_ticks_reg))
                    begin
                        // Leave survival with a fresh power-up
                        stable_cnt_next  = '0;
                        cycle_tally_next = '0;
                        power_line_next  = 1'b1;
                        reset_line_next  = 1'b1;
                        first_next       = 1'b1;
                        pin_cnt_next     = '0;
                        bus_cnt_next     = '0;
                        reset_tally_next = '0;
                        safe             = 1'b1;
                        state_next       = ST_OK;
                    end
                end
                else
                    stable_cnt_next = '0;
            end
            default:
                state_next = ST_OK;
        endcase

        // Map state to reported code
        unique case (state_next)
            ST_OK:    code = CODE_OK;
            ST_BUS:   code = CODE_BUS;
            ST_PIN:   code = CODE_PIN;
            ST_RESET: code = CODE_RESET;
            ST_CYCLE: code = CODE_CYCLE;
            ST_SURV:  code = CODE_SURV;
            default:  code = CODE_OK;
        endcase

        // Pack the result beat
        m_data_next = {6'b0, cycle_tally_next, safe, recover, link, missed, code,
                       power_line_next, reset_line_next, beat_next};
    end

    // Advance state on each accepted poll beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_OK;
            beat_reg          <= 1'b0;
            last_p1_reg       <= 1'b0;
            last_p2_reg       <= 1'b0;
            last_cnt_reg      <= '0;
            first_reg         <= 1'b1;
            pin_cnt_reg       <= '0;
            bus_cnt_reg       <= '0;
            off_cnt_reg       <= '0;
            stable_cnt_reg    <= '0;
            reset_tally_reg   <= '0;
            recover_tally_reg <= '0;
            cycle_tally_reg   <= '0;
            reset_line_reg    <= 1'b1;
            power_line_reg    <= 1'b1;
        end
        else if (accept)
        begin
            state_reg         <= state_next;
            beat_reg          <= beat_next;
            last_p1_reg       <= last_p1_next;
            last_p2_reg       <= last_p2_next;
            last_cnt_reg      <= last_cnt_next;
            first_reg         <= first_next;
            pin_cnt_reg       <= pin_cnt_next;
            bus_cnt_reg       <= bus_cnt_next;
            off_cnt_reg       <= off_cnt_next;
            stable_cnt_reg    <= stable_cnt_next;
            reset_tally_reg   <= reset_tally_next;
            recover_tally_reg <= recover_tally_next;
            cycle_tally_reg   <= cycle_tally_next;
            reset_line_reg    <= reset_line_next;
            power_line_reg    <= power_line_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_data_reg <= m_data_next;
    end

endmodule
